// File: hw/rtl/sus_pkg.sv
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and constants for the sorted unique set unit.
// ----------------------------------------------------------------------------
package sus_pkg;

  localparam int ValueW          = 32;
  localparam int CountW          = 5;
  localparam int CapacityDefault = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic shift_in;
    logic shift_out;
  } cell_ctl_t;

endpackage

// File: hw/rtl/sus_req_if.sv
// ----------------------------------------------------------------------------
// sus_req_if
// Request channel: operation kind and element value.
// ----------------------------------------------------------------------------
interface sus_req_if;
  import sus_pkg::*;

  logic                     valid;
  logic                     ready;
  req_type_e                req_type;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// File: hw/rtl/sus_rsp_if.sv
// ----------------------------------------------------------------------------
// sus_rsp_if
// Response channel: presence, overflow flag and element count.
// ----------------------------------------------------------------------------
interface sus_rsp_if;
  import sus_pkg::*;

  logic              valid;
  logic              ready;
  logic              present;
  logic              overflow;
  logic [CountW-1:0] count;

  modport source (output valid, output present, output overflow, output count, input ready);
  modport sink   (input valid, input present, input overflow, input count, output ready);
endinterface

// File: hw/rtl/sus_cell.sv
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted chain: holds an element, compares it with the
// request key and shifts toward or away from its neighbors.
// ----------------------------------------------------------------------------
module sus_cell (
  input  logic                              clk_i,
  input  logic                              valid_i,
  input  logic signed [sus_pkg::ValueW-1:0] key_i,
  input  sus_pkg::cell_ctl_t                ctl_i,
  input  logic signed [sus_pkg::ValueW-1:0] left_data_i,
  input  logic                              left_after_i,
  input  logic signed [sus_pkg::ValueW-1:0] right_data_i,
  output logic signed [sus_pkg::ValueW-1:0] data_o,
  output logic                              after_o,
  output logic                              eq_o
);
  import sus_pkg::*;

  logic signed [ValueW-1:0] data_q, data_d;
  logic                     ge;

  assign ge      = valid_i && (data_q >= key_i);
  assign eq_o    = valid_i && (data_q == key_i);
  assign after_o = !valid_i || ge;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_in && after_o) begin
      data_d = left_after_i ? left_data_i : key_i;
    end else if (ctl_i.shift_out && ge) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: hw/rtl/sorted_unique_set_unit.sv
// ----------------------------------------------------------------------------
// sorted_unique_set_unit
// Set of distinct signed 32-bit values kept in ascending order in a chain
// of cells, with insert, erase, find and clear requests.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while the output register is empty
// or being drained, so also while the previous response is still waiting,
// and its response appears in that register on the next cycle. Every cell
// compares its element with the request value at once, so the first cell
// not below the value is found in that same cycle, and an insert or erase
// shifts the cells behind it by one place toward or away from their
// neighbors. No clearing pass after reset is needed.
module sorted_unique_set_unit #(
  parameter int CAPACITY = sus_pkg::CapacityDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sus_req_if.sink  req_i,
  sus_rsp_if.source rsp_o
);
  import sus_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0]          count_q, count_d;
  logic                     rsp_valid_q;
  logic                     present_q, overflow_q;
  logic                     accept;
  logic                     hit, full;
  logic                     do_insert, do_erase;
  cell_ctl_t                ctl;

  logic signed [ValueW-1:0] cell_data  [CAPACITY];
  logic                     cell_after [CAPACITY];
  logic [CAPACITY-1:0]      cell_eq;
  logic [CntW+CountW-1:0]   count_ext;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign hit       = |cell_eq;
  assign full      = (count_q == CntW'(CAPACITY));
  assign do_insert = accept && (req_i.req_type == REQ_INSERT) && !hit && !full;
  assign do_erase  = accept && (req_i.req_type == REQ_ERASE) && hit;

  assign ctl.shift_in  = do_insert;
  assign ctl.shift_out = do_erase;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     valid;
    logic signed [ValueW-1:0] left_data, right_data;
    logic                     left_after;

    assign valid = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign left_data  = req_i.value;
      assign left_after = 1'b0;
    end else begin : g_inner
      assign left_data  = cell_data[i-1];
      assign left_after = cell_after[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_body
      assign right_data = cell_data[i+1];
    end

    sus_cell u_cell (
      .clk_i        (clk_i),
      .valid_i      (valid),
      .key_i        (req_i.value),
      .ctl_i        (ctl),
      .left_data_i  (left_data),
      .left_after_i (left_after),
      .right_data_i (right_data),
      .data_o       (cell_data[i]),
      .after_o      (cell_after[i]),
      .eq_o         (cell_eq[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (accept && (req_i.req_type == REQ_CLEAR)) begin
      count_d = '0;
    end else if (do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (do_erase) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      present_q  <= hit;
      overflow_q <= (req_i.req_type == REQ_INSERT) && !hit && full;
    end
  end

  assign count_ext      = {{CountW{1'b0}}, count_q};
  assign rsp_o.valid    = rsp_valid_q;
  assign rsp_o.present  = present_q;
  assign rsp_o.overflow = overflow_q;
  assign rsp_o.count    = count_ext[CountW-1:0];

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_eq))
    else $error("value matched in more than one cell");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.req_type == REQ_CLEAR) |=> count_q == '0)
    else $error("clear left elements behind");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && overflow_q |-> full && !present_q)
    else $error("overflow reported on a set that is not full");
`endif

endmodule
